// File: hw/rtl/e2d_pkg.sv
package e2d_pkg;

    localparam int unsigned ManW = 64;
    localparam int unsigned SeW  = 16;
    localparam int unsigned DblW = 64;

    localparam logic [14:0] ExpAllOnes = 15'h7FFF;
    localparam logic [63:0] DblInf     = 64'h7FF0000000000000;
    localparam logic [63:0] DblQnan    = 64'h7FF8000000000000;
    localparam logic [63:0] DblSnan    = 64'h7FF4000000000000;
    // Extended bias minus double bias.
    localparam logic [15:0] BiasDiff   = 16'd15360;

    typedef enum logic [2:0] {
        t_CLS_QNAN,
        t_CLS_SNAN,
        t_CLS_ZERO,
        t_CLS_INF,
        t_CLS_FINITE
    } t_class;

    typedef struct packed {
        t_class      cls;
        logic        sign;
        logic [52:0] keep;
        logic [16:0] be;
    } t_stage;

endpackage

// File: hw/rtl/e2d_round53.sv
module e2d_round53 (
    input  logic [63:0]          i_mantissa,
    input  logic [15:0]          i_sign_exponent,
    output e2d_pkg::t_stage      o_stage
);
    import e2d_pkg::*;

    logic [14:0] w_exp;
    logic        w_ib;
    logic [53:0] w_keep;
    logic [10:0] w_rem;
    logic        w_up;

    always_comb begin
        w_exp  = i_sign_exponent[14:0];
        w_ib   = i_mantissa[63];
        w_rem  = i_mantissa[10:0];
        w_up   = (w_rem > 11'h400) || (w_rem == 11'h400 && i_mantissa[11]);
        w_keep = {1'b0, i_mantissa[63:11]} + {53'd0, w_up};
        o_stage.sign = i_sign_exponent[15];
        o_stage.be   = {2'b00, w_exp} - {1'b0, BiasDiff};
        o_stage.keep = w_keep[52:0];
        if (w_keep[53]) begin
            o_stage.keep = {1'b1, 52'd0};
            o_stage.be   = o_stage.be + 17'd1;
        end
        if ((w_exp == '0) == w_ib) begin
            o_stage.cls = t_CLS_QNAN;
        end else if (w_exp == '0) begin
            o_stage.cls = t_CLS_ZERO;
        end else if (w_exp == ExpAllOnes) begin
            if (i_mantissa[62:0] == '0) begin
                o_stage.cls = t_CLS_INF;
            end else if (i_mantissa[62]) begin
                o_stage.cls = t_CLS_QNAN;
            end else begin
                o_stage.cls = t_CLS_SNAN;
            end
        end else begin
            o_stage.cls = t_CLS_FINITE;
        end
    end

endmodule

// File: hw/rtl/e2d_pack.sv
module e2d_pack (
    input  e2d_pkg::t_stage      i_stage,
    output logic [63:0]          o_double_bits
);
    import e2d_pkg::*;

    logic [16:0]  w_sh;
    logic [5:0]   w_shn;
    logic [105:0] w_wide;
    logic [52:0]  w_q;
    logic [52:0]  w_r;
    logic         w_up;
    logic [52:0]  w_dn;
    logic [63:0]  w_s;

    always_comb begin
        w_s    = {i_stage.sign, 63'd0};
        w_sh   = 17'd1 - i_stage.be;
        w_shn  = w_sh[5:0];
        w_wide = {i_stage.keep, 53'd0} >> w_shn;
        w_q    = w_wide[105:53];
        w_r    = w_wide[52:0];
        w_up   = w_r[52] && ((w_r[51:0] != '0) || w_q[0]);
        w_dn   = w_q + {52'd0, w_up};
        unique case (i_stage.cls)
            t_CLS_QNAN: o_double_bits = DblQnan;
            t_CLS_SNAN: o_double_bits = DblSnan;
            t_CLS_ZERO: o_double_bits = w_s;
            t_CLS_INF:  o_double_bits = w_s | DblInf;
            default: begin
                if (!i_stage.be[16] && i_stage.be >= 17'd2047) begin
                    o_double_bits = w_s | DblInf;
                end else if (!i_stage.be[16] && i_stage.be != '0) begin
                    o_double_bits = {i_stage.sign, i_stage.be[10:0], i_stage.keep[51:0]};
                end else if (w_sh > 17'd54) begin
                    o_double_bits = w_s;
                end else begin
                    o_double_bits = w_s | {11'd0, w_dn};
                end
            end
        endcase
    end

endmodule

// File: hw/rtl/extended80_to_double_convert.sv
// Converts x87 80-bit extended values into IEEE-754 double bit patterns.
// Input channel: i_valid/o_ready with i_mantissa (64-bit significand with
// explicit integer bit) and i_sign_exponent (sign and biased exponent).
// Output channel: o_valid/i_ready with o_double_bits.
// Each transaction is registered at the input, then rounded to 53 bits,
// classified and packed in one combinational pass into the result register.
// o_valid rises once the result register has taken the packed result.
// Throughput is one transaction per cycle while the receiver keeps taking
// results; the two register stages advance together whenever the result
// register is empty or being taken. When the receiver stalls, the result
// register holds, the input register still fills if empty, and o_ready
// falls once both are full, so no transaction is lost or repeated.
// Reset clears both valid flags; payload registers are not reset.
module extended80_to_double_convert (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [e2d_pkg::ManW-1:0]  i_mantissa,
    input  logic [e2d_pkg::SeW-1:0]   i_sign_exponent,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [e2d_pkg::DblW-1:0]  o_double_bits
);
    import e2d_pkg::*;

    logic        r_in_valid;
    logic [63:0] r_mantissa;
    logic [15:0] r_sign_exponent;
    logic        r_out_valid;
    logic [63:0] r_double_bits;
    logic        w_adv_out;
    logic        w_adv_in;
    t_stage      w_stage;
    logic [63:0] n_double_bits;

    assign w_adv_out = !r_out_valid || i_ready;
    assign w_adv_in  = !r_in_valid || w_adv_out;
    assign o_ready   = w_adv_in;
    assign o_valid   = r_out_valid;
    assign o_double_bits = r_double_bits;

    e2d_round53 u_round (
        .i_mantissa      (r_mantissa),
        .i_sign_exponent (r_sign_exponent),
        .o_stage         (w_stage)
    );

    e2d_pack u_pack (
        .i_stage       (w_stage),
        .o_double_bits (n_double_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_in) begin
                r_in_valid <= i_valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in && i_valid) begin
            r_mantissa      <= i_mantissa;
            r_sign_exponent <= i_sign_exponent;
        end
        if (w_adv_out && r_in_valid) begin
            r_double_bits <= n_double_bits;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_double_bits))
        else $error("Result changed while stalled.");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid)
        else $error("Not ready with room available.");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv_out |=> r_out_valid)
        else $error("Transaction lost between stages.");

endmodule
